[hw/rtl/ecc_pkg.sv]
// Shared constants for the Euler circuit check block.
// Used by ecc_ffs and euler_circuit_check; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package ecc_pkg;

   localparam int ID_WIDTH = 6;
   localparam int ID_SPACE = 64;
   localparam int COUNT_WIDTH = 7;
   localparam logic [COUNT_WIDTH-1:0] COUNT_RESET = 7'd64;

   localparam logic KIND_EDGE = 1'b0;
   localparam logic KIND_FINISH = 1'b1;

endpackage

`default_nettype wire

[hw/rtl/ecc_ffs.sv]
// Find-first-set unit: lowest set bit of a vertex set as one-hot mask and index.
// Depends on ecc_pkg for the vertex id width.
`timescale 1ns / 1ps
`default_nettype none

module ecc_ffs #(
   parameter int WIDTH = 64
) (
   input  wire logic [WIDTH-1:0]              vec,
   output logic                               found,
   output logic [WIDTH-1:0]                   onehot,
   output logic [ecc_pkg::ID_WIDTH-1:0]       index
);

   always_comb begin
      found  = |vec;
      onehot = vec & (~vec + WIDTH'(1));
      index  = '0;
      for (int i = 0; i < WIDTH; i++) begin
         index = index | (onehot[i] ? ecc_pkg::ID_WIDTH'(i) : '0);
      end
   end

endmodule

`default_nettype wire

[hw/rtl/euler_circuit_check.sv]
// Top level of the Euler circuit check: edge loading, connectivity walk, result.
// Depends on ecc_pkg and ecc_ffs.
//
// Usage: a transaction on the req_ channel with req_kind = edge adds the
// undirected edge req_end_a - req_end_b; with req_kind = finish it evaluates
// the loaded graph, returns one transaction on the rsp_ channel and clears
// the graph. Edge transactions return nothing. An endpoint at or above the
// vertex count drops the edge and makes the next result report status 1.
// The csr_ channel writes the vertex count and is always ready.
// Work: an edge makes two read-modify-write passes through the adjacency
// memory, one per endpoint row. A finish walks the reached component, and
// each reached vertex costs one lowest-bit search and one memory row read.
// A finish that skips the walk goes straight to the done state; one that
// walks alternates between the pick and merge states until the frontier is
// empty. The done state loads the result once the output is free.
// The result sits in an output register; edge transactions are accepted
// while it waits, and a second finish holds until it has been taken.
// Reset clears the graph, the sticky error and the output, and sets the
// vertex count to 64. The adjacency memory needs no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module euler_circuit_check #(
   parameter int MAX_VERTICES = 64
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  req_valid,
   output logic                                       req_ready,
   input  wire logic                                  req_kind,
   input  wire logic [ecc_pkg::ID_WIDTH-1:0]          req_end_a,
   input  wire logic [ecc_pkg::ID_WIDTH-1:0]          req_end_b,
   output logic                                       rsp_valid,
   input  wire logic                                  rsp_ready,
   output logic                                       rsp_eulerian,
   output logic                                       rsp_status,
   input  wire logic                                  csr_valid,
   output logic                                       csr_ready,
   input  wire logic [ecc_pkg::COUNT_WIDTH-1:0]       csr_vertex_count
);

   localparam int NODES = (MAX_VERTICES < ecc_pkg::ID_SPACE) ? MAX_VERTICES
                                                              : ecc_pkg::ID_SPACE;
   localparam int AW = $clog2(NODES);

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_WR_A  = 3'd1;
   localparam logic [2:0] S_WR_B  = 3'd2;
   localparam logic [2:0] S_PICK  = 3'd3;
   localparam logic [2:0] S_MERGE = 3'd4;
   localparam logic [2:0] S_DONE  = 3'd5;

   logic [2:0]                       state_ff, state_in;
   logic [ecc_pkg::COUNT_WIDTH-1:0]  vcount_ff, vcount_in;
   logic [AW-1:0]                    a_ff, a_in, b_ff, b_in;
   logic [NODES-1:0]                 parity_ff, parity_in;
   logic [NODES-1:0]                 touched_ff, touched_in;
   logic [NODES-1:0]                 reached_ff, reached_in;
   logic [NODES-1:0]                 frontier_ff, frontier_in;
   logic                             range_err_ff, range_err_in;
   logic                             res_eul_ff, res_eul_in;
   logic                             res_status_ff, res_status_in;
   logic                             rsp_valid_ff, rsp_valid_in;
   logic                             rsp_eul_ff, rsp_eul_in;
   logic                             rsp_status_ff, rsp_status_in;

   logic [NODES-1:0]                 adj_mem [NODES];
   logic [NODES-1:0]                 rd_data_ff;
   logic [AW-1:0]                    rd_addr;
   logic                             wr_en;
   logic [AW-1:0]                    wr_addr;
   logic [NODES-1:0]                 wr_data;

   logic [NODES-1:0]                 ffs_vec;
   logic                             ffs_found;
   logic [NODES-1:0]                 ffs_onehot;
   logic [ecc_pkg::ID_WIDTH-1:0]     ffs_index;

   logic                             req_fire;
   logic                             ok_a, ok_b;
   logic [NODES-1:0]                 bit_a, bit_b, row_old, fresh;

   ecc_ffs #(
      .WIDTH(NODES)
   ) u_ffs (
      .vec    (ffs_vec),
      .found  (ffs_found),
      .onehot (ffs_onehot),
      .index  (ffs_index)
   );

   assign req_ready    = (state_ff == S_IDLE);
   assign csr_ready    = 1'b1;
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_eulerian = rsp_eul_ff;
   assign rsp_status   = rsp_status_ff;

   assign req_fire = req_valid && req_ready;
   assign ok_a = ({1'b0, req_end_a} < vcount_ff) && (int'(req_end_a) < NODES);
   assign ok_b = ({1'b0, req_end_b} < vcount_ff) && (int'(req_end_b) < NODES);
   assign bit_a = NODES'(1) << a_ff;
   assign bit_b = NODES'(1) << b_ff;
   assign ffs_vec = (state_ff == S_PICK) ? frontier_ff : touched_ff;

   always_comb begin
      state_in      = state_ff;
      vcount_in     = vcount_ff;
      a_in          = a_ff;
      b_in          = b_ff;
      parity_in     = parity_ff;
      touched_in    = touched_ff;
      reached_in    = reached_ff;
      frontier_in   = frontier_ff;
      range_err_in  = range_err_ff;
      res_eul_in    = res_eul_ff;
      res_status_in = res_status_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_eul_in    = rsp_eul_ff;
      rsp_status_in = rsp_status_ff;
      rd_addr       = a_ff;
      wr_en         = 1'b0;
      wr_addr       = a_ff;
      wr_data       = '0;
      row_old       = '0;
      fresh         = '0;

      if (csr_valid && csr_ready) begin
         vcount_in = csr_vertex_count;
      end

      case (state_ff)
         S_IDLE: begin
            rd_addr = req_end_a[AW-1:0];
            if (req_fire) begin
               if (req_kind == ecc_pkg::KIND_EDGE) begin
                  if (ok_a && ok_b) begin
                     a_in     = req_end_a[AW-1:0];
                     b_in     = req_end_b[AW-1:0];
                     state_in = S_WR_A;
                  end else begin
                     range_err_in = 1'b1;
                  end
               end else if (range_err_ff) begin
                  res_eul_in    = 1'b0;
                  res_status_in = 1'b1;
                  state_in      = S_DONE;
               end else if ((parity_ff != '0) || !ffs_found) begin
                  res_eul_in    = 1'b0;
                  res_status_in = 1'b0;
                  state_in      = S_DONE;
               end else begin
                  reached_in  = ffs_onehot;
                  frontier_in = ffs_onehot;
                  state_in    = S_PICK;
               end
            end
         end
         S_WR_A: begin
            row_old  = touched_ff[a_ff] ? rd_data_ff : '0;
            wr_en    = 1'b1;
            wr_addr  = a_ff;
            wr_data  = row_old | bit_b;
            rd_addr  = b_ff;
            state_in = S_WR_B;
         end
         S_WR_B: begin
            row_old    = touched_ff[b_ff] ? rd_data_ff : '0;
            wr_en      = 1'b1;
            wr_addr    = b_ff;
            wr_data    = row_old | bit_a;
            parity_in  = parity_ff ^ bit_a ^ bit_b;
            touched_in = touched_ff | bit_a | bit_b;
            state_in   = S_IDLE;
         end
         S_PICK: begin
            rd_addr = ffs_index[AW-1:0];
            if (ffs_found) begin
               frontier_in = frontier_ff & ~ffs_onehot;
               state_in    = S_MERGE;
            end else begin
               res_eul_in    = (reached_ff == touched_ff);
               res_status_in = 1'b0;
               state_in      = S_DONE;
            end
         end
         S_MERGE: begin
            fresh       = rd_data_ff & touched_ff & ~reached_ff;
            reached_in  = reached_ff | fresh;
            frontier_in = frontier_ff | fresh;
            state_in    = S_PICK;
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in  = 1'b1;
               rsp_eul_in    = res_eul_ff;
               rsp_status_in = res_status_ff;
               parity_in     = '0;
               touched_in    = '0;
               reached_in    = '0;
               frontier_in   = '0;
               range_err_in  = 1'b0;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         vcount_ff     <= ecc_pkg::COUNT_RESET;
         parity_ff     <= '0;
         touched_ff    <= '0;
         reached_ff    <= '0;
         frontier_ff   <= '0;
         range_err_ff  <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         vcount_ff     <= vcount_in;
         parity_ff     <= parity_in;
         touched_ff    <= touched_in;
         reached_ff    <= reached_in;
         frontier_ff   <= frontier_in;
         range_err_ff  <= range_err_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      a_ff          <= a_in;
      b_ff          <= b_in;
      res_eul_ff    <= res_eul_in;
      res_status_ff <= res_status_in;
      rsp_eul_ff    <= rsp_eul_in;
      rsp_status_ff <= rsp_status_in;
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= adj_mem[rd_addr];
      if (wr_en) begin
         adj_mem[wr_addr] <= wr_data;
      end
   end

`ifndef ASSERT_OFF
   a_reached_in_touched: assert property (@(posedge clock) disable iff (reset)
      (reached_ff & ~touched_ff) == '0)
      else $error("reached set holds an untouched vertex");

   a_frontier_in_reached: assert property (@(posedge clock) disable iff (reset)
      (frontier_ff & ~reached_ff) == '0)
      else $error("frontier holds a vertex outside the reached set");

   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == S_DONE))
      else $error("response raised outside the done state");

   a_error_result: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_status_ff) |-> !rsp_eul_ff)
      else $error("range error reported together with a circuit");

   a_error_finish: assert property (@(posedge clock) disable iff (reset)
      (req_fire && (req_kind == ecc_pkg::KIND_FINISH) && range_err_ff)
         |=> (state_ff == S_DONE) && res_status_ff)
      else $error("finish after a range error skipped the walk incorrectly");
`endif

endmodule

`default_nettype wire
